@@ design/vcap_pkg.sv @@
`timescale 1ns / 1ps

package vcap_pkg;

  // Default edge length of the cube.
  localparam int EDGE_DEF = 32;

  // Fractional bits of the reciprocal used to split a word index.
  localparam int DIV_SHIFT = 20;

  // Width of the fixed word index field.
  localparam int IDX_W = 10;

  // Width of the fixed data fields.
  localparam int DATA_W = 32;

  // Transform modes.
  localparam logic [1:0] MODE_BIT  = 2'd0;
  localparam logic [1:0] MODE_WORD = 2'd1;
  localparam logic [1:0] MODE_SWAP = 2'd2;

  // Operation codes.
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  // Register index of the transform mode register.
  localparam logic REG_MODE = 1'b0;

endpackage

@@ design/voxel_cube_axis_permuter.sv @@
`timescale 1ns / 1ps

// Channel   Direction  Signals                                        Word
// in        input      in_valid_i / in_ready_o                        op, word_index, write_word
// out       output     out_valid_o / out_ready_i                      read_word
// cfg       APB        psel, penable, pwrite, paddr, pwdata, prdata   transform_mode
//
// A write word goes straight into the single-port cube memory.
// A read word passes S_DIV and S_FIX, which split the index, and S_BASE, which sets the
// first row address; then the memory port yields one stored row per cycle while a shift
// register collects one bit of each row, or takes the whole single row in the word mode.
// Reset clears the control state and the mode register; the cube memory is not cleared.
// A finished word waits in the output register; a new read stalls in its last step
// until that register is free, and no input word is taken meanwhile.
module voxel_cube_axis_permuter #(
  parameter int EDGE = vcap_pkg::EDGE_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        op_i,
  input  logic [vcap_pkg::IDX_W-1:0]  word_index_i,
  input  logic [vcap_pkg::DATA_W-1:0] write_word_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [vcap_pkg::DATA_W-1:0] read_word_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [2:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  localparam int CELLS = EDGE * EDGE;
  localparam int AW    = $clog2(CELLS);
  localparam int IW    = $clog2(EDGE);
  localparam int CW    = IW + 1;
  localparam int XW    = 14;
  localparam int RW    = 18;
  localparam int MW    = vcap_pkg::IDX_W + RW;
  localparam int PW    = MW - vcap_pkg::DIV_SHIFT;
  localparam int RECIP = (1 << vcap_pkg::DIV_SHIFT) / EDGE;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_DIV    = 7'b0000010,
    S_FIX    = 7'b0000100,
    S_BASE   = 7'b0001000,
    S_GATHER = 7'b0010000,
    S_DRAIN  = 7'b0100000,
    S_OUT    = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  logic [1:0]                  mode_q;
  logic [vcap_pkg::IDX_W-1:0]  idx_q;
  logic [PW-1:0]               pest_q;
  logic                        oob_q;
  logic [IW-1:0]               p_q, p_d;
  logic [IW-1:0]               q_q, q_d;
  logic [IW-1:0]               col_q;
  logic [AW-1:0]               addr_q;
  logic [CW-1:0]               cnt_q;
  logic                        rd_valid_q;
  logic [EDGE-1:0]             acc_q;
  logic                        out_valid_q;
  logic [vcap_pkg::DATA_W-1:0] out_data_q;

  logic                        in_fire;
  logic                        cfg_we;
  logic                        mem_we;
  logic [AW-1:0]               mem_addr;
  logic [EDGE-1:0]             mem_rdata;
  logic [MW-1:0]               prod;
  logic [XW-1:0]               rem;
  logic                        last_issue;
  logic                        out_load;
  logic                        word_mode;
  logic                        bit_mode;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign word_mode  = (mode_q == vcap_pkg::MODE_WORD);
  assign bit_mode   = (mode_q == vcap_pkg::MODE_BIT);

  // Configuration port.
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready && (paddr[2] == vcap_pkg::REG_MODE);
  assign prdata = (paddr[2] == vcap_pkg::REG_MODE) ? {30'd0, mode_q} : 32'd0;

  // Memory port: writes come from the input in idle, reads from the gather address.
  assign mem_we   = in_fire && (op_i == vcap_pkg::OP_WRITE) &&
                    (XW'(word_index_i) < XW'(CELLS));
  assign mem_addr = (state_q == S_GATHER) ? addr_q : AW'(word_index_i);

  vcap_ram #(
    .WIDTH (EDGE),
    .DEPTH (CELLS)
  ) u_cube (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (EDGE'(write_word_i)),
    .rdata_o (mem_rdata)
  );

  // The index is split by a floor reciprocal, so the estimate is low by at most one.
  assign prod = MW'(idx_q) * MW'(RECIP);
  assign rem  = XW'(idx_q) - XW'(pest_q) * XW'(EDGE);

  always_comb begin
    if (rem >= XW'(EDGE)) begin
      p_d = IW'(pest_q + PW'(1));
      q_d = IW'(rem - XW'(EDGE));
    end else begin
      p_d = IW'(pest_q);
      q_d = IW'(rem);
    end
  end

  assign last_issue = word_mode ? (cnt_q == '0) : (cnt_q == CW'(EDGE - 1));
  assign out_load   = (state_q == S_OUT) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire && (op_i == vcap_pkg::OP_READ)) begin
          state_d = S_DIV;
        end
      end
      S_DIV:    state_d = S_FIX;
      S_FIX:    state_d = oob_q ? S_OUT : S_BASE;
      S_BASE:   state_d = S_GATHER;
      S_GATHER: state_d = last_issue ? S_DRAIN : S_GATHER;
      S_DRAIN:  state_d = S_OUT;
      S_OUT:    state_d = out_load ? S_IDLE : S_OUT;
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mode_q      <= vcap_pkg::MODE_BIT;
      rd_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q    <= state_d;
      rd_valid_q <= (state_q == S_GATHER);
      if (cfg_we) begin
        mode_q <= pwdata[1:0];
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == S_BASE) begin
        cnt_q <= '0;
      end else if (state_q == S_GATHER) begin
        cnt_q <= cnt_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      idx_q <= word_index_i;
    end
    if (state_q == S_DIV) begin
      pest_q <= prod[MW-1:vcap_pkg::DIV_SHIFT];
      oob_q  <= XW'(idx_q) >= XW'(CELLS);
    end
    if (state_q == S_FIX) begin
      p_q <= p_d;
      q_q <= q_d;
      if (oob_q) begin
        acc_q <= '0;
      end
    end
    if (state_q == S_BASE) begin
      // Bit mode walks layer p and picks column q; the swap modes walk layer q, the word mode reads only row p of it.
      if (bit_mode) begin
        addr_q <= AW'(p_q) * AW'(EDGE);
        col_q  <= q_q;
      end else if (word_mode) begin
        addr_q <= AW'(q_q) * AW'(EDGE) + AW'(p_q);
        col_q  <= p_q;
      end else begin
        addr_q <= AW'(q_q) * AW'(EDGE);
        col_q  <= p_q;
      end
    end else if (state_q == S_GATHER) begin
      addr_q <= addr_q + AW'(1);
    end
    if (rd_valid_q) begin
      if (word_mode) begin
        acc_q <= mem_rdata;
      end else begin
        acc_q <= {acc_q[EDGE-2:0], mem_rdata[IW'(EDGE - 1) - col_q]};
      end
    end
    if (out_load) begin
      out_data_q <= vcap_pkg::DATA_W'(acc_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign read_word_o = out_data_q;

  a_we_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> state_q == S_IDLE)
    else $error("cube write outside idle");

  a_oob_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIX && oob_q) |=> (state_q == S_OUT && acc_q == '0))
    else $error("out of range read not zeroed");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(EDGE))
    else $error("gather counter overran");

  a_rd_after_gather: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_valid_q |-> $past(state_q == S_GATHER))
    else $error("read data flagged without a gather issue");

endmodule

@@ design/vcap_ram.sv @@
`timescale 1ns / 1ps

module vcap_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

  localparam int SIDE         = vcap_pkg::EDGE_DEF;
  localparam int CELLS        = SIDE * SIDE;
  localparam int READ_LAT     = SIDE + 5;
  localparam int DRAIN        = 2 * READ_LAT;
  localparam int GAP_MAX      = 18;
  localparam int HOLD_CYCLES  = 800;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int REPORT_LIMIT = 10;
  localparam int IW           = vcap_pkg::IDX_W;
  localparam int DW           = vcap_pkg::DATA_W;

  // The unused mode code, which the block treats as the axis swap.
  localparam logic [1:0] MODE_ALIAS = 2'd3;
  localparam logic [2:0] MODE_ADDR  = 3'(4 * vcap_pkg::REG_MODE);

  logic          clk_i = 1'b0;
  logic          rst_ni;
  logic          in_valid_i;
  logic          in_ready_o;
  logic          op_i;
  logic [IW-1:0] word_index_i;
  logic [DW-1:0] write_word_i;
  logic          out_valid_o;
  logic          out_ready_i = 1'b0;
  logic [DW-1:0] read_word_o;
  logic          psel;
  logic          penable;
  logic          pwrite;
  logic [2:0]    paddr;
  logic [31:0]   pwdata;
  logic [31:0]   prdata;
  logic          pready;

  // Shadow of the cube and the mode register, and the words still owed by the block.
  logic [DW-1:0] cube_ref [CELLS];
  bit            written_ref [CELLS];
  logic [1:0]    mode_ref;
  logic [DW-1:0] pending_words [$];

  int unsigned mismatches;
  int unsigned in_gap_max;
  int unsigned out_gap_max;
  int unsigned out_stall_left;
  bit          out_hold;
  int unsigned cycles = 0;

  voxel_cube_axis_permuter u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .op_i         (op_i),
    .word_index_i (word_index_i),
    .write_word_i (write_word_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .read_word_o  (read_word_o),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic logic [DW-1:0] permute_word(logic [IW-1:0] idx);
    int p;
    int q;
    logic [DW-1:0] res;
    p = idx / SIDE;
    q = idx % SIDE;
    res = '0;
    case (mode_ref)
      vcap_pkg::MODE_BIT: begin
        for (int r = 0; r < SIDE; r++) res[SIDE-1-r] = cube_ref[p*SIDE+r][SIDE-1-q];
      end
      vcap_pkg::MODE_WORD: begin
        res = cube_ref[q*SIDE+p];
      end
      default: begin
        for (int r = 0; r < SIDE; r++) res[SIDE-1-r] = cube_ref[q*SIDE+r][SIDE-1-p];
      end
    endcase
    return res;
  endfunction

  function automatic bit layer_full(int layer);
    bit full;
    full = 1'b1;
    for (int r = 0; r < SIDE; r++) full &= written_ref[layer*SIDE+r];
    return full;
  endfunction

  // A read must never gather a word that was not written yet.
  function automatic bit read_ok(logic [IW-1:0] idx);
    int p;
    int q;
    p = idx / SIDE;
    q = idx % SIDE;
    case (mode_ref)
      vcap_pkg::MODE_BIT:  return layer_full(p);
      vcap_pkg::MODE_WORD: return written_ref[q*SIDE+p];
      default:             return layer_full(q);
    endcase
  endfunction

  function automatic logic [DW-1:0] random_word();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return 32'h8000_0000 >> $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  task automatic note_mismatch(string what, logic [31:0] want, logic [31:0] got);
    mismatches++;
    if (mismatches <= REPORT_LIMIT)
      $display("%0t: %s: expected %08h, got %08h", $time, what, want, got);
  endtask

  task automatic send_word(logic op, logic [IW-1:0] idx, logic [DW-1:0] data);
    int unsigned gap;
    gap = $urandom_range(0, in_gap_max);
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    op_i         <= op;
    word_index_i <= idx;
    write_word_i <= data;
    do @(posedge clk_i); while (!in_ready_o);
    if (op == vcap_pkg::OP_WRITE) begin
      cube_ref[idx]    = data;
      written_ref[idx] = 1'b1;
    end else begin
      pending_words.push_back(permute_word(idx));
    end
  endtask

  // Falls back to a write when no legal read index turns up.
  task automatic send_random(int unsigned read_pct);
    logic [IW-1:0] idx;
    bit found;
    found = 1'b0;
    idx = '0;
    if ($urandom_range(1, 100) <= read_pct) begin
      for (int t = 0; t < 8 && !found; t++) begin
        idx = IW'($urandom);
        found = read_ok(idx);
      end
    end
    if (found) send_word(vcap_pkg::OP_READ, idx, $urandom);
    else send_word(vcap_pkg::OP_WRITE, IW'($urandom), random_word());
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
  endtask

  task automatic apb_access(logic wr, logic [2:0] addr, logic [31:0] data,
                            output logic [31:0] rdata);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic check_mode_reg();
    logic [31:0] rdata;
    apb_access(1'b0, MODE_ADDR, '0, rdata);
    if (rdata !== 32'(mode_ref)) note_mismatch("mode register", 32'(mode_ref), rdata);
  endtask

  task automatic set_mode(logic [1:0] mode);
    logic [31:0] unused;
    wait_idle();
    apb_access(1'b1, MODE_ADDR, 32'(mode), unused);
    mode_ref = mode;
    check_mode_reg();
  endtask

  task automatic hold_receiver(int unsigned n);
    @(posedge clk_i);
    out_hold = 1'b1;
    repeat (n) @(posedge clk_i);
    out_hold = 1'b0;
  endtask

  always @(negedge clk_i) begin
    if (!rst_ni || out_hold) begin
      out_ready_i <= 1'b0;
    end else if (out_stall_left != 0) begin
      out_stall_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin : check_words
    logic [DW-1:0] want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_words.size() == 0) begin
        note_mismatch("word with none pending", 'x, read_word_o);
      end else begin
        want = pending_words.pop_front();
        if (read_word_o !== want) note_mismatch("read_word", want, read_word_o);
      end
      out_stall_left = $urandom_range(0, out_gap_max);
    end
  end

  task automatic test_mode_register();
    check_mode_reg();
    set_mode(vcap_pkg::MODE_WORD);
    set_mode(vcap_pkg::MODE_SWAP);
    set_mode(MODE_ALIAS);
    set_mode(vcap_pkg::MODE_BIT);
  endtask

  // In the word mode a read at p*SIDE+q returns the stored word at q*SIDE+p.
  task automatic test_word_extremes();
    set_mode(vcap_pkg::MODE_WORD);
    send_word(vcap_pkg::OP_WRITE, 10'd0, 32'hFFFF_FFFF);
    send_word(vcap_pkg::OP_WRITE, 10'd1023, 32'h0000_0000);
    send_word(vcap_pkg::OP_WRITE, 10'd31, 32'h8000_0001);
    send_word(vcap_pkg::OP_WRITE, 10'd992, 32'h7FFF_FFFE);
    send_word(vcap_pkg::OP_WRITE, 10'd33, 32'hAAAA_AAAA);
    send_word(vcap_pkg::OP_WRITE, 10'd33, 32'h5555_5555);
    send_word(vcap_pkg::OP_READ, 10'd0, $urandom);
    send_word(vcap_pkg::OP_READ, 10'd1023, $urandom);
    send_word(vcap_pkg::OP_READ, 10'd992, $urandom);
    send_word(vcap_pkg::OP_READ, 10'd31, $urandom);
    send_word(vcap_pkg::OP_READ, 10'd33, $urandom);
  endtask

  // Layer 0 gets the identity pattern; every finished layer is read back at once.
  task automatic test_fill_cube();
    set_mode(vcap_pkg::MODE_BIT);
    for (int layer = 0; layer < SIDE; layer++) begin
      for (int row = 0; row < SIDE; row++)
        send_word(vcap_pkg::OP_WRITE, IW'(layer*SIDE + row),
                  layer == 0 ? 32'h8000_0000 >> row : random_word());
      repeat (2)
        send_word(vcap_pkg::OP_READ, IW'(layer*SIDE + $urandom_range(0, SIDE-1)), $urandom);
    end
  endtask

  task automatic test_random_mix(logic [1:0] mode, int n, int unsigned gap);
    set_mode(mode);
    in_gap_max  = gap;
    out_gap_max = gap;
    repeat (n) send_random(60);
    in_gap_max  = GAP_MAX;
    out_gap_max = GAP_MAX;
  endtask

  task automatic test_output_backpressure();
    set_mode(vcap_pkg::MODE_SWAP);
    in_gap_max  = 0;
    out_gap_max = 0;
    fork
      hold_receiver(HOLD_CYCLES);
    join_none
    repeat (40) send_random(100);
    in_gap_max  = GAP_MAX;
    out_gap_max = GAP_MAX;
  endtask

  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    op_i           = vcap_pkg::OP_WRITE;
    word_index_i   = '0;
    write_word_i   = '0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    mode_ref       = vcap_pkg::MODE_BIT;
    mismatches     = 0;
    in_gap_max     = GAP_MAX;
    out_gap_max    = GAP_MAX;
    out_stall_left = 0;
    out_hold       = 1'b0;
    foreach (written_ref[i]) written_ref[i] = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    test_mode_register();
    test_word_extremes();
    test_fill_cube();
    test_random_mix(vcap_pkg::MODE_SWAP, 150, GAP_MAX);
    test_random_mix(MODE_ALIAS, 120, GAP_MAX);
    test_random_mix(vcap_pkg::MODE_WORD, 150, 0);
    test_random_mix(vcap_pkg::MODE_BIT, 150, GAP_MAX);
    test_output_backpressure();
    wait_idle();

    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/vcap_pkg.sv
design/vcap_ram.sv
design/voxel_cube_axis_permuter.sv
tb/tb_top.sv
